@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DATA_W = 32;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 5;
	localparam int DEFAULT_DEPTH = 16;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic ins;
		logic rem;
		logic signed [DATA_W-1:0] value;
	} spq_op_t;

endpackage

@@ rtl/spq_cell.sv @@
`timescale 1ns / 1ps

module spq_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W = 5
) (
	input  logic                                    clk,
	input  spq_pkg::spq_op_t                        op,
	input  logic [CNT_W-1:0]                        count,
	input  logic                                    prev_gt,
	input  logic signed [spq_pkg::DATA_W-1:0]       prev_value,
	input  logic signed [spq_pkg::DATA_W-1:0]       next_value,
	output logic                                    gt,
	output logic                                    eq,
	output logic signed [spq_pkg::DATA_W-1:0]       value
);

	logic signed [spq_pkg::DATA_W-1:0] value_q;
	logic                              occ;

	assign occ   = CNT_W'(CELL_IDX) < count;
	assign gt    = occ && (value_q > op.value);
	assign eq    = occ && (value_q == op.value);
	assign value = value_q;

	// insert: hold ahead of the slot, drop the word in, shift the rest back
	// remove: pull the next word forward from the match onward
	always_ff @(posedge clk) begin
		if (op.ins && !gt) begin
			value_q <= prev_gt ? op.value : prev_value;
		end else if (op.rem && !gt) begin
			value_q <= next_value;
		end
	end

endmodule

@@ rtl/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// Sorted priority queue of signed 32-bit words, largest at the head.
// Input channel: in_valid / in_stall with kind (insert, remove, find) and
// item_value. Output channel: out_valid / out_stall with status, head_value,
// head_valid and entry_count, one result word per input word.
// Every cell of the chain compares its word with item_value in parallel and
// shifts toward or away from its neighbor, so an operation finishes in the
// cycle it is accepted; its result is registered and shows in the next cycle.
// Throughput is one operation per cycle while out_stall stays low.
// While a result waits under out_stall, in_stall is raised and the queue
// holds its contents; the result and the head fields stay steady.
// An insert into a full queue reports full; remove and find report not
// found when no entry matches. Reset (arst_n low) empties the queue and
// drops any pending result; no clearing pass is needed.

module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [spq_pkg::KIND_W-1:0]               kind,
	input  logic signed [spq_pkg::DATA_W-1:0]        item_value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [spq_pkg::STATUS_W-1:0]             status,
	output logic signed [spq_pkg::DATA_W-1:0]        head_value,
	output logic                                     head_valid,
	output logic [spq_pkg::COUNT_W-1:0]              entry_count
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_CNT_W = spq_pkg::COUNT_W;

	logic [CNT_W-1:0]                  count_q;
	logic                              out_valid_q;
	logic [spq_pkg::STATUS_W-1:0]      status_q;
	logic                              accept;
	logic                              full;
	logic                              found;
	logic [spq_pkg::STATUS_W-1:0]      status_d;
	spq_pkg::spq_op_t                  op;
	logic [QUEUE_DEPTH-1:0]            gt_vec;
	logic [QUEUE_DEPTH-1:0]            eq_vec;
	logic signed [spq_pkg::DATA_W-1:0] cell_val [QUEUE_DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign found    = |eq_vec;

	assign op.ins   = accept && (kind == spq_pkg::KIND_INSERT) && !full;
	assign op.rem   = accept && (kind == spq_pkg::KIND_REMOVE) && found;
	assign op.value = item_value;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			spq_cell #(
				.CELL_IDX(gi),
				.CNT_W(CNT_W)
			) u_cell (
				.clk(clk),
				.op(op),
				.count(count_q),
				.prev_gt(gi == 0 ? 1'b1 : gt_vec[(gi == 0) ? 0 : gi - 1]),
				.prev_value(cell_val[(gi == 0) ? 0 : gi - 1]),
				.next_value(cell_val[(gi == QUEUE_DEPTH - 1) ? gi : gi + 1]),
				.gt(gt_vec[gi]),
				.eq(eq_vec[gi]),
				.value(cell_val[gi])
			);
		end
	endgenerate

	always_comb begin
		case (kind)
			spq_pkg::KIND_INSERT: status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
			spq_pkg::KIND_REMOVE: status_d = found ? spq_pkg::ST_DONE : spq_pkg::ST_NOT_FOUND;
			spq_pkg::KIND_FIND:   status_d = found ? spq_pkg::ST_DONE : spq_pkg::ST_NOT_FOUND;
			default:              status_d = spq_pkg::ST_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (op.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign head_valid  = count_q != '0;
	assign head_value  = head_valid ? cell_val[0] : '0;
	assign entry_count = OUT_CNT_W'(count_q);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with no pending result");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the queue");

	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(count_q))
		else $error("queue changed while result was held");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_val[0] >= cell_val[1])
		else $error("head entries out of order");
`endif

endmodule
